FILE: src/dll_pkg.sv
// shared types and constants for the linked list engine
package dll_pkg;

  localparam int CAPACITY_DEF = 32;
  localparam int MAX_OUT = 32;

  localparam logic [3:0] OP_CLEAR     = 4'd0;
  localparam logic [3:0] OP_INS_FRONT = 4'd1;
  localparam logic [3:0] OP_INS_END   = 4'd2;
  localparam logic [3:0] OP_INS_AT    = 4'd3;
  localparam logic [3:0] OP_INS_AFTER = 4'd4;
  localparam logic [3:0] OP_DEL_FRONT = 4'd5;
  localparam logic [3:0] OP_DEL_END   = 4'd6;
  localparam logic [3:0] OP_DEL_AT    = 4'd7;
  localparam logic [3:0] OP_READ      = 4'd8;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_BADPOS = 2'd1;
  localparam logic [1:0] ST_EMPTY  = 2'd2;
  localparam logic [1:0] ST_FULL   = 2'd3;

  // datapath operation selected by the controller
  typedef enum logic [3:0] {
    DP_NONE    = 4'd0,
    DP_LOAD    = 4'd1,  // capture input beat, start walk at first node
    DP_STEP    = 4'd2,  // read next link of current node
    DP_ADV     = 4'd3,  // move current to fetched next link
    DP_CLRSTEP = 4'd4,  // clear link valid bits, list pointers and count
    DP_LINK    = 4'd5,  // take new node from free head, read its next link
    DP_FIXA    = 4'd6,  // write new node, advance free head
    DP_FIXB    = 4'd7,  // patch neighbors a and b
    DP_RDPREV  = 4'd8,  // read prev/next of current
    DP_FREE    = 4'd9   // return current node to free chain
  } dp_op_t;

  typedef struct packed {
    dp_op_t     op;
    logic       out_load;
    logic [1:0] out_status;
    logic       out_elem;
    logic       out_last;
  } dll_cmd_t;

  typedef struct packed {
    logic       cur_null;
    logic       nxt_null;
    logic       free_null;
    logic       empty;
    logic       pos_ok;
    logic       walk_done;
    logic       clr_done;
    logic       out_busy;
    logic [3:0] opcode;
  } dll_stat_t;

endpackage

FILE: src/dll_if.sv
// valid/ready channel interface
interface dll_if #(parameter int W = 8);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: src/dll_ram.sv
// generic single write port ram with registered read
module dll_ram #(
  parameter int W = 32,
  parameter int D = 32
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);
  logic [W-1:0] mem [D];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

FILE: src/dll_datapath.sv
// node store, list pointers and output register
module dll_datapath import dll_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic [3:0]  in_opcode,
  input  logic [7:0]  in_position,
  input  logic [31:0] in_value,
  input  dll_cmd_t    cmd,
  output dll_stat_t   stat,
  input  logic        out_ready,
  output logic        out_valid,
  output logic [1:0]  out_status,
  output logic [31:0] out_element,
  output logic [5:0]  out_length,
  output logic        out_last
);
  localparam int AW = $clog2(CAPACITY);
  localparam int PW = AW + 1;  // msb marks null
  localparam logic [PW-1:0] NIL = {1'b1, {AW{1'b0}}};
  localparam logic [PW-1:0] LASTN = PW'(CAPACITY - 1);

  logic [PW-1:0] first_r, final_r, free_r, cur_r, a_r, b_r, new_r;
  logic [PW-1:0] first_nxt, final_nxt, free_nxt, cur_nxt, a_nxt, b_nxt, new_nxt;
  logic [PW-1:0] cnt_r, cnt_nxt, walk_r, walk_nxt;
  logic [3:0]    op_r;
  logic [7:0]    pos_r;
  logic [31:0]   val_r;
  logic [1:0]    fix_r, fix_nxt;  // pending patches

  // next-link ram with valid bits (reset = free chain)
  logic [CAPACITY-1:0] nv_r, nv_nxt;
  logic          n_we, p_we, v_we;
  logic [AW-1:0] n_wa, p_wa, n_ra, p_ra;
  logic [PW-1:0] n_wd, p_wd, n_rd, p_rd;
  logic [AW-1:0] n_ra_r;
  logic [PW-1:0] nxt_link;
  logic [31:0]   v_rd;

  dll_ram #(.W(PW), .D(CAPACITY)) u_next (.clk, .we(n_we), .waddr(n_wa),
    .wdata(n_wd), .raddr(n_ra), .rdata(n_rd));
  dll_ram #(.W(PW), .D(CAPACITY)) u_prev (.clk, .we(p_we), .waddr(p_wa),
    .wdata(p_wd), .raddr(p_ra), .rdata(p_rd));
  dll_ram #(.W(32), .D(CAPACITY)) u_val (.clk, .we(v_we), .waddr(new_r[AW-1:0]),
    .wdata(val_r), .raddr(n_ra), .rdata(v_rd));

  always_comb begin
    if (nv_r[n_ra_r]) nxt_link = n_rd;
    else if (n_ra_r == LASTN[AW-1:0]) nxt_link = NIL;
    else nxt_link = PW'(n_ra_r) + PW'(1);
  end

  logic [1:0] ost_r;
  logic [31:0] oel_r;
  logic ov_r, olast_r;
  logic [5:0] olen_r;

  always_comb begin
    first_nxt = first_r; final_nxt = final_r; free_nxt = free_r;
    cur_nxt = cur_r; a_nxt = a_r; b_nxt = b_r; new_nxt = new_r;
    cnt_nxt = cnt_r; walk_nxt = walk_r; nv_nxt = nv_r; fix_nxt = fix_r;
    n_we = 1'b0; p_we = 1'b0; v_we = 1'b0;
    n_wa = cur_r[AW-1:0]; p_wa = cur_r[AW-1:0];
    n_wd = NIL; p_wd = NIL;
    n_ra = cur_r[AW-1:0]; p_ra = cur_r[AW-1:0];
    unique case (cmd.op)
      DP_LOAD: begin
        cur_nxt = first_r;
        walk_nxt = PW'(1);
        fix_nxt = 2'b00;
        unique case (in_opcode)
          OP_INS_FRONT: begin a_nxt = NIL; b_nxt = first_r; end
          OP_INS_END:   begin a_nxt = final_r; b_nxt = NIL; end
          OP_DEL_END:   cur_nxt = final_r;
          default: ;
        endcase
      end
      DP_STEP: n_ra = cur_r[AW-1:0];
      DP_ADV: begin
        cur_nxt = nxt_link;
        walk_nxt = walk_r + PW'(1);
      end
      DP_RDPREV: begin
        // registered read issued here, consumed in FREE or LINK setup
        n_ra = cur_r[AW-1:0];
        p_ra = cur_r[AW-1:0];
      end
      DP_CLRSTEP: begin
        nv_nxt = '0;
        first_nxt = NIL; final_nxt = NIL; free_nxt = '0; cnt_nxt = '0;
      end
      DP_LINK: begin
        // positional inserts derive neighbors from the walked node
        if (op_r == OP_INS_AT) begin
          a_nxt = p_rd; b_nxt = cur_r;
        end else if (op_r == OP_INS_AFTER) begin
          a_nxt = cur_r; b_nxt = nxt_link;
        end
        new_nxt = free_r;
        n_ra = free_r[AW-1:0];
        fix_nxt = 2'b11;
      end
      DP_FIXA: begin
        // new node written; free head advances by its old next link
        free_nxt = nxt_link;
        v_we = 1'b1;
        n_we = 1'b1; n_wa = new_r[AW-1:0]; n_wd = b_r;
        nv_nxt[new_r[AW-1:0]] = 1'b1;
        p_we = 1'b1; p_wa = new_r[AW-1:0]; p_wd = a_r;
        cnt_nxt = cnt_r + PW'(1);
        if (a_r[PW-1]) first_nxt = new_r;
        if (b_r[PW-1]) final_nxt = new_r;
        fix_nxt = 2'b01;
      end
      DP_FIXB: begin
        if (fix_r[1]) begin
          // unlink: a.next=b, b.prev=a; node was freed in FREE
          if (!a_r[PW-1]) begin
            n_we = 1'b1; n_wa = a_r[AW-1:0]; n_wd = b_r;
            nv_nxt[a_r[AW-1:0]] = 1'b1;
          end else first_nxt = b_r;
          if (!b_r[PW-1]) begin
            p_we = 1'b1; p_wa = b_r[AW-1:0]; p_wd = a_r;
          end else final_nxt = a_r;
          fix_nxt = 2'b00;
        end else begin
          if (!a_r[PW-1]) begin
            n_we = 1'b1; n_wa = a_r[AW-1:0]; n_wd = new_r;
            nv_nxt[a_r[AW-1:0]] = 1'b1;
          end
          if (!b_r[PW-1]) begin
            p_we = 1'b1; p_wa = b_r[AW-1:0]; p_wd = new_r;
          end
          fix_nxt = 2'b00;
        end
      end
      DP_FREE: begin
        // capture neighbors of cur from the read issued in RDPREV
        a_nxt = p_rd; b_nxt = nxt_link;
        n_we = 1'b1; n_wa = cur_r[AW-1:0]; n_wd = free_r;
        nv_nxt[cur_r[AW-1:0]] = 1'b1;
        free_nxt = cur_r;
        cnt_nxt = cnt_r - PW'(1);
        fix_nxt = 2'b10;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    n_ra_r <= n_ra;
    if (cmd.op == DP_LOAD) begin
      op_r <= in_opcode; pos_r <= in_position; val_r <= in_value;
    end
    cur_r <= cur_nxt; a_r <= a_nxt; b_r <= b_nxt; new_r <= new_nxt;
    walk_r <= walk_nxt;
    if (!rst_n) begin
      nv_r <= '0; first_r <= NIL; final_r <= NIL; free_r <= '0; cnt_r <= '0;
      fix_r <= 2'b00; ov_r <= 1'b0;
    end else begin
      nv_r <= nv_nxt; first_r <= first_nxt; final_r <= final_nxt;
      free_r <= free_nxt; cnt_r <= cnt_nxt; fix_r <= fix_nxt;
      if (cmd.out_load) ov_r <= 1'b1;
      else if (out_ready) ov_r <= 1'b0;
    end
    if (cmd.out_load) begin
      ost_r <= cmd.out_status;
      oel_r <= cmd.out_elem ? v_rd : 32'd0;
      olen_r <= 6'(cnt_nxt);
      olast_r <= cmd.out_last;
    end
  end

  logic [PW:0] cnt_w;
  assign cnt_w = {1'b0, cnt_r};

  assign stat.cur_null  = cur_r[PW-1];
  assign stat.nxt_null  = nxt_link[PW-1];
  assign stat.free_null = free_r[PW-1];
  assign stat.empty     = first_r[PW-1];
  assign stat.pos_ok    = (pos_r != 8'd0) && ({1'b0, pos_r} <= 9'(cnt_w));
  assign stat.walk_done = (8'(walk_r) == pos_r);
  assign stat.clr_done  = 1'b1;
  assign stat.out_busy  = ov_r && !out_ready;
  assign stat.opcode    = op_r;

  assign out_valid = ov_r;
  assign out_status = ost_r;
  assign out_element = oel_r;
  assign out_length = olen_r;
  assign out_last = olast_r;
endmodule

FILE: src/dll_ctrl.sv
// command sequencer for the linked list engine
module dll_ctrl import dll_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  dll_stat_t stat,
  output dll_cmd_t  cmd
);
  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_DISP  = 9'b000000010,
    S_WALK  = 9'b000000100,
    S_ADV   = 9'b000001000,
    S_ACT   = 9'b000010000,
    S_LINK  = 9'b000100000,
    S_FIX   = 9'b001000000,
    S_FREE  = 9'b010000000,
    S_RDOUT = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;
  logic [5:0] k_r, k_nxt;

  function automatic dll_cmd_t res(input logic [1:0] st);
    dll_cmd_t c;
    c = '0;
    c.op = DP_NONE; c.out_load = 1'b1; c.out_status = st; c.out_last = 1'b1;
    return c;
  endfunction

  always_comb begin
    state_nxt = state_r;
    k_nxt = k_r;
    cmd = '0;
    cmd.op = DP_NONE;
    in_ready = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        // every command starts with a fresh beat count
        k_nxt = '0;
        in_ready = !stat.out_busy;
        if (in_valid && !stat.out_busy) begin
          cmd.op = DP_LOAD;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        k_nxt = '0;
        unique case (stat.opcode) inside
          OP_CLEAR: begin
            cmd = res(ST_OK); cmd.op = DP_CLRSTEP; state_nxt = S_IDLE;
          end
          OP_INS_FRONT, OP_INS_END: begin
            if (stat.free_null) begin cmd = res(ST_FULL); state_nxt = S_IDLE; end
            else begin cmd.op = DP_LINK; state_nxt = S_LINK; end
          end
          OP_INS_AT, OP_INS_AFTER, OP_DEL_AT: begin
            if (!stat.pos_ok) begin cmd = res(ST_BADPOS); state_nxt = S_IDLE; end
            else if (stat.walk_done) state_nxt = S_ACT;
            else begin cmd.op = DP_STEP; state_nxt = S_ADV; end
          end
          OP_DEL_FRONT, OP_DEL_END: begin
            if (stat.cur_null) begin cmd = res(ST_EMPTY); state_nxt = S_IDLE; end
            else begin cmd.op = DP_RDPREV; state_nxt = S_FREE; end
          end
          OP_READ: begin
            if (stat.cur_null) begin cmd = res(ST_EMPTY); state_nxt = S_IDLE; end
            else begin cmd.op = DP_STEP; state_nxt = S_RDOUT; end
          end
          default: begin cmd = res(ST_OK); state_nxt = S_IDLE; end
        endcase
      end
      S_WALK: begin
        if (stat.walk_done) state_nxt = S_ACT;
        else begin cmd.op = DP_STEP; state_nxt = S_ADV; end
      end
      S_ADV: begin
        cmd.op = DP_ADV; state_nxt = S_WALK;
      end
      S_ACT: begin
        // cur holds the target node; fetch its links, or report full for an insert with no free node
        if (stat.opcode == OP_DEL_AT) begin
          cmd.op = DP_RDPREV; state_nxt = S_FREE;
        end else if (stat.free_null) begin
          cmd = res(ST_FULL); state_nxt = S_IDLE;
        end else begin
          cmd.op = DP_RDPREV; state_nxt = S_LINK;
        end
      end
      S_LINK: begin
        // for front/end this is the free-head read cycle
        if (stat.opcode == OP_INS_AT || stat.opcode == OP_INS_AFTER) begin
          cmd.op = DP_LINK;
          state_nxt = S_FIX;
          k_nxt = 6'd1;
        end else begin
          cmd.op = DP_FIXA; state_nxt = S_FIX; k_nxt = 6'd0;
        end
      end
      S_FIX: begin
        if (k_r == 6'd1) begin
          cmd.op = DP_FIXA; k_nxt = 6'd0;
        end else begin
          cmd = res(ST_OK); cmd.op = DP_FIXB; state_nxt = S_IDLE;
        end
      end
      S_FREE: begin
        cmd.op = DP_FREE; state_nxt = S_FIX; k_nxt = 6'd0;
      end
      S_RDOUT: begin
        // value and next link of cur are read; emit one beat once the output is not busy
        if (!stat.out_busy) begin
          cmd.out_load = 1'b1;
          cmd.out_status = ST_OK;
          cmd.out_elem = 1'b1;
          cmd.out_last = stat.nxt_null || (k_r == 6'(MAX_OUT - 1));
          cmd.op = DP_ADV;
          k_nxt = k_r + 6'd1;
          if (cmd.out_last) state_nxt = S_IDLE;
          else state_nxt = S_DISP;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    // read out continues through dispatch with current advanced
    if (state_r == S_DISP && stat.opcode == OP_READ && k_r != 6'd0) begin
      k_nxt = k_r;
      cmd = '0; cmd.op = DP_STEP; state_nxt = S_RDOUT;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; k_r <= '0;
    end else begin
      state_r <= state_nxt; k_r <= k_nxt;
    end
  end
endmodule

FILE: src/doubly_linked_list_engine_core.sv
// top level of the linked list engine
// front/end inserts and deletes need no walk; positional ones walk node by node first
// read out: one node access per cycle through the link ram, stalling while output is busy
// throughput: one command at a time; positional walks bound the command rate
// reset: synchronous, list empty and free chain restored at once through link valid bits
module doubly_linked_list_engine_core import dll_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input logic clk,
  input logic rst_n,
  dll_if.sink   in_ch,
  dll_if.source out_ch
);
  dll_cmd_t  cmd;
  dll_stat_t stat;

  dll_ctrl u_ctrl (.clk, .rst_n, .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .stat, .cmd);

  dll_datapath #(.CAPACITY(CAPACITY)) u_dp (
    .clk, .rst_n,
    .in_opcode(in_ch.data[43:40]),
    .in_position(in_ch.data[39:32]),
    .in_value(in_ch.data[31:0]),
    .cmd, .stat,
    .out_ready(out_ch.ready), .out_valid(out_ch.valid),
    .out_status(out_ch.data[40:39]),
    .out_element(out_ch.data[38:7]),
    .out_length(out_ch.data[6:1]),
    .out_last(out_ch.data[0]));
endmodule
